// File: rtl/core/masked_route_table_unit_defines.svh
// ----------------------------------------------------------------------------
// masked route table unit: assertion macros
// shared property forms for the concurrent checks of the route table
// ----------------------------------------------------------------------------
`ifndef MASKED_ROUTE_TABLE_UNIT_DEFINES_SVH
`define MASKED_ROUTE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// types, codes and defaults shared by the masked route table files
// ----------------------------------------------------------------------------
`default_nettype none

package mrt_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int ADDR_W      = 32;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_ADD_OK = 2'd0;
	localparam logic [1:0] ST_HIT    = 2'd1;
	localparam logic [1:0] ST_MISS   = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] lookup_addr;
		logic [ADDR_W-1:0] next_hop_in;
		logic [ADDR_W-1:0] match_net;
		logic [ADDR_W-1:0] match_mask;
	} mrt_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] net;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] hop;
	} mrt_entry_t;

	localparam int ENTRY_W = $bits(mrt_entry_t);

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       write;
		logic       rd;
		logic       ptr_clr;
		logic       res_set;
		logic [1:0] res_code;
		logic       res_hop;
		logic       emit;
	} mrt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_add;
		logic full;
		logic empty;
		logic hit;
		logic last;
		logic out_free;
	} mrt_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/mrt_req_if.sv
// ----------------------------------------------------------------------------
// mrt_req_if
// request channel: add or lookup word with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mrt_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [mrt_pkg::ADDR_W-1:0] lookup_addr;
	logic [mrt_pkg::ADDR_W-1:0] next_hop_in;
	logic [mrt_pkg::ADDR_W-1:0] match_net;
	logic [mrt_pkg::ADDR_W-1:0] match_mask;

	modport source (
		output valid, opcode, lookup_addr, next_hop_in, match_net, match_mask,
		input  ready
	);
	modport sink (
		input  valid, opcode, lookup_addr, next_hop_in, match_net, match_mask,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/core/mrt_rsp_if.sv
// ----------------------------------------------------------------------------
// mrt_rsp_if
// response channel: status and next hop word with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mrt_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [mrt_pkg::ADDR_W-1:0] next_hop_out;

	modport source (
		output valid, status, next_hop_out,
		input  ready
	);
	modport sink (
		input  valid, status, next_hop_out,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/core/masked_route_table_unit.sv
// ----------------------------------------------------------------------------
// masked_route_table_unit
// first-match masked route table: add appends an entry unless full, lookup scans
// the filled entries in insertion order and returns the first matching next hop
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req      in   opcode, lookup_addr, next_hop_in, match_net, match_mask
//  rsp      out  status, next_hop_out
//
//  add: capture, dispatch and finish steps from accept to the next accept; lookup
//  adds a scan step for each entry up to the first match, or up to the last
//  filled entry on a miss; a lookup on an empty table skips the scan.
//  the scan reads one entry per cycle through the registered entry ram port.
//  reset clears the fill count, the scan pointer and the handshake state only.
//  a stalled rsp holds the block in its last step until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "masked_route_table_unit_defines.svh"

module masked_route_table_unit #(
	parameter int ENTRIES = mrt_pkg::ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mrt_req_if.sink   req,
	mrt_rsp_if.source rsp
);

	mrt_pkg::mrt_item_t item;
	mrt_pkg::mrt_cmd_t  cmd;
	mrt_pkg::mrt_sts_t  sts;
	logic               in_ready;

	assign item = '{opcode: req.opcode, lookup_addr: req.lookup_addr,
		next_hop_in: req.next_hop_in, match_net: req.match_net,
		match_mask: req.match_mask};
	assign req.ready = in_ready;

	mrt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mrt_datapath #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_status(rsp.status),
		.out_hop   (rsp.next_hop_out)
	);

	`MRT_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "second word taken mid-item")
	`MRT_ASSERT_NOW(a_no_write_full, cmd.write, !sts.full, "entry written into a full table")
	`MRT_ASSERT_NOW(a_hop_zero, rsp.valid && rsp.status != mrt_pkg::ST_HIT, rsp.next_hop_out == '0, "nonzero hop without hit")
	`MRT_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "response overwritten before taken")

endmodule

`default_nettype wire

// File: rtl/core/mrt_ram.sv
// ----------------------------------------------------------------------------
// mrt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mrt_ctrl.sv
// ----------------------------------------------------------------------------
// mrt_ctrl
// sequencer for add, table scan and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mrt_pkg::mrt_sts_t sts,
	output mrt_pkg::mrt_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_DISPATCH = 2'd1;
	localparam logic [1:0] S_SCAN     = 2'd2;
	localparam logic [1:0] S_FINISH   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.is_add) begin
					cmd.res_set = 1'b1;
					if (sts.full) begin
						cmd.res_code = mrt_pkg::ST_FULL;
					end else begin
						cmd.write    = 1'b1;
						cmd.res_code = mrt_pkg::ST_ADD_OK;
					end
					state_d = S_FINISH;
				end else if (sts.empty) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = mrt_pkg::ST_MISS;
					state_d      = S_FINISH;
				end else begin
					cmd.rd      = 1'b1;
					cmd.ptr_clr = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = mrt_pkg::ST_HIT;
					cmd.res_hop  = 1'b1;
					state_d      = S_FINISH;
				end else if (sts.last) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = mrt_pkg::ST_MISS;
					state_d      = S_FINISH;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mrt_datapath.sv
// ----------------------------------------------------------------------------
// mrt_datapath
// item capture, entry ram, fill count, masked compare and output register
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_datapath #(
	parameter int ENTRIES = mrt_pkg::ENTRIES_DEF,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W = $clog2(ENTRIES + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mrt_pkg::mrt_item_t         item,
	input  wire mrt_pkg::mrt_cmd_t          cmd,
	output mrt_pkg::mrt_sts_t               sts,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      out_status,
	output logic [mrt_pkg::ADDR_W-1:0]      out_hop
);

	mrt_pkg::mrt_item_t  item_q;
	mrt_pkg::mrt_entry_t wr_entry;
	mrt_pkg::mrt_entry_t rd_entry;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [IDX_W-1:0]    rd_addr;
	logic [1:0]          res_status_q;
	logic [mrt_pkg::ADDR_W-1:0] res_hop_q;
	logic                out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	assign wr_entry = '{net: item_q.match_net, mask: item_q.match_mask,
		hop: item_q.next_hop_in};
	assign rd_addr  = cmd.ptr_clr ? '0 : ptr_q[IDX_W-1:0];

	mrt_ram #(
		.WIDTH(mrt_pkg::ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(wr_entry),
		.re   (cmd.rd),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.rd) begin
				ptr_q <= CNT_W'(rd_addr) + CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result staging and output word
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			res_hop_q    <= cmd.res_hop ? rd_entry.hop : '0;
		end
		if (cmd.emit) begin
			out_status <= res_status_q;
			out_hop    <= res_hop_q;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.is_add   = (item_q.opcode == mrt_pkg::OP_ADD);
	assign sts.full     = (count_q == CNT_W'(ENTRIES));
	assign sts.empty    = (count_q == '0);
	assign sts.hit      = ((item_q.lookup_addr & rd_entry.mask) ==
		(rd_entry.net & rd_entry.mask));
	assign sts.last     = (ptr_q == count_q);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// File: test/tb_masked_route_table_unit.sv
// ----------------------------------------------------------------------------
// tb_masked_route_table_unit
// self-checking bench for the masked route table: adds and lookups with
// random pacing on both channels, each response word checked in order
// against a behavioral table kept in a scoreboard class
// ----------------------------------------------------------------------------
`default_nettype none

module tb_masked_route_table_unit;

	import mrt_pkg::*;

	localparam int ENTRIES = ENTRIES_DEF;
	localparam int RANDOM_WORDS = 1850;

	typedef struct {
		logic [1:0]        status;
		logic [ADDR_W-1:0] hop;
	} route_result_t;

	class route_scoreboard;
		mrt_entry_t    routes[ENTRIES];
		int unsigned   fill;
		route_result_t pending_results[$];
		int unsigned   errors;
		int unsigned   seen;

		function new();
			fill = 0;
			errors = 0;
			seen = 0;
		endfunction

		function void note_request(mrt_item_t w);
			route_result_t r;
			bit found;
			r.status = ST_MISS;
			r.hop = '0;
			found = 0;
			if (w.opcode == OP_ADD) begin
				if (fill < ENTRIES) begin
					routes[fill].net = w.match_net;
					routes[fill].mask = w.match_mask;
					routes[fill].hop = w.next_hop_in;
					fill++;
					r.status = ST_ADD_OK;
				end else begin
					r.status = ST_FULL;
				end
			end else begin
				for (int i = 0; i < fill; i++) begin
					if (!found && (w.lookup_addr & routes[i].mask) ==
							(routes[i].net & routes[i].mask)) begin
						found = 1;
						r.status = ST_HIT;
						r.hop = routes[i].hop;
					end
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_response(logic [1:0] st, logic [ADDR_W-1:0] hop);
			route_result_t e;
			seen++;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected word: expected none, actual status %0d next hop %h",
					$time, st, hop);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (st !== e.status) begin
				$display("%0t status mismatch: expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (hop !== e.hop) begin
				$display("%0t next hop mismatch: expected %h actual %h", $time, e.hop, hop);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mrt_req_if req_ch ();
	mrt_rsp_if rsp_ch ();

	masked_route_table_unit #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	route_scoreboard sb = new();

	logic [ADDR_W-1:0] gen_net[ENTRIES];
	logic [ADDR_W-1:0] gen_mask[ENTRIES];
	int unsigned       gen_fill = 0;
	int unsigned       send_calm = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic mrt_item_t make_word(logic op, logic [ADDR_W-1:0] addr,
			logic [ADDR_W-1:0] hop, logic [ADDR_W-1:0] net, logic [ADDR_W-1:0] mask);
		mrt_item_t w;
		w.opcode = op;
		w.lookup_addr = addr;
		w.next_hop_in = hop;
		w.match_net = net;
		w.match_mask = mask;
		return w;
	endfunction

	task automatic offer_word(input mrt_item_t w);
		int unsigned n;
		if (send_calm > 0) begin
			send_calm--;
		end else begin
			n = pick_gap();
			repeat (n) begin
				@(negedge clk);
				req_ch.valid = 1'b0;
			end
			if ($urandom_range(0, 39) == 0)
				send_calm = $urandom_range(20, 80);
		end
		if (w.opcode == OP_ADD && gen_fill < ENTRIES) begin
			gen_net[gen_fill] = w.match_net;
			gen_mask[gen_fill] = w.match_mask;
			gen_fill++;
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.opcode = w.opcode;
		req_ch.lookup_addr = w.lookup_addr;
		req_ch.next_hop_in = w.next_hop_in;
		req_ch.match_net = w.match_net;
		req_ch.match_mask = w.match_mask;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	// accepted words on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				sb.note_request(make_word(req_ch.opcode, req_ch.lookup_addr,
					req_ch.next_hop_in, req_ch.match_net, req_ch.match_mask));
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				sb.check_response(rsp_ch.status, rsp_ch.next_hop_out);
		end
	end

	// response side pacing, with one long hold-off to back up the block
	initial begin
		int unsigned stall_left;
		int unsigned calm_left;
		bit squeezed;
		stall_left = 0;
		calm_left = 0;
		squeezed = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeezed && sb.seen >= 300) begin
				squeezed = 1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 99) == 0)
					calm_left = $urandom_range(100, 300);
				else
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		mrt_item_t w;
		int unsigned r;
		int unsigned plen;
		int unsigned j;
		bit is_add;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ADD;
		req_ch.lookup_addr = '0;
		req_ch.next_hop_in = '0;
		req_ch.match_net = '0;
		req_ch.match_mask = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// lookups on an empty table
		offer_word(make_word(OP_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 32'h0));
		offer_word(make_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		// host routes at both ends, then a short prefix
		offer_word(make_word(OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		offer_word(make_word(OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF));
		offer_word(make_word(OP_ADD, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0A00_0000,
			32'hFF00_0000));
		offer_word(make_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
		offer_word(make_word(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		offer_word(make_word(OP_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 32'h0));
		offer_word(make_word(OP_LOOKUP, 32'h0AFF_FFFF, 32'h0, 32'h0, 32'h0));
		offer_word(make_word(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0));
		offer_word(make_word(OP_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 32'h0));
		offer_word(make_word(OP_LOOKUP, 32'h0000_0001, 32'h0, 32'h0, 32'h0));

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			r = $urandom_range(0, 99);
			is_add = (gen_fill < ENTRIES) ? (r < 25) : (r < 5);
			w = make_word(is_add ? OP_ADD : OP_LOOKUP, $urandom(), $urandom(),
				$urandom(), $urandom());
			if (is_add) begin
				plen = $urandom_range(1, 32);
				w.match_mask = 32'hFFFF_FFFF << (32 - plen);
				if ($urandom_range(0, 7) == 0)
					w.match_mask = $urandom();
				// default route in the last slot now and then
				if (gen_fill == ENTRIES - 1 && $urandom_range(0, 1) == 1)
					w.match_mask = '0;
			end else if (gen_fill > 0 && $urandom_range(0, 9) < 7) begin
				j = $urandom_range(0, gen_fill - 1);
				w.lookup_addr = (gen_net[j] & gen_mask[j]) | ($urandom() & ~gen_mask[j]);
			end
			offer_word(w);
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
